@@ rtl/core/dcf_pkg.sv @@
`default_nettype none

package dcf_pkg;

    // Four packet lanes, one per motor channel.
    localparam int NumLanes = 4;
    localparam int LaneIdxW = 2;
    localparam int CmdW     = 11;
    localparam int ValW     = 16;
    localparam int ProdW    = 26;

    // value kinds
    localparam logic [1:0] KIND_RAW  = 2'd0;
    localparam logic [1:0] KIND_PCT  = 2'd1;
    localparam logic [1:0] KIND_US   = 2'd2;
    localparam logic [1:0] KIND_STOP = 2'd3;

    // rate codes
    localparam logic [1:0] RATE_150 = 2'd0;
    localparam logic [1:0] RATE_300 = 2'd1;
    localparam logic [1:0] RATE_600 = 2'd2;
    localparam logic [1:0] RATE_RSV = 2'd3;

    // register indexes
    localparam logic [1:0] REG_RATE  = 2'd0;
    localparam logic [1:0] REG_FLOOR = 2'd1;
    localparam logic [1:0] REG_CEIL  = 2'd2;

    localparam logic [1:0]      RATE_RESET  = RATE_300;
    localparam logic [CmdW-1:0] FLOOR_RESET = 11'd48;
    localparam logic [CmdW-1:0] CEIL_RESET  = 11'd2047;

    // 100.0 percent in Q7.8, pulse width limits
    localparam logic [ValW-1:0] PCT_FULL = 16'd25600;
    localparam logic [ValW-1:0] US_MIN   = 16'd1000;
    localparam logic [ValW-1:0] US_MAX   = 16'd2000;

    // d/10 = (d*820)>>13, exact for d < 1024
    localparam logic [9:0]  RECIP_10   = 10'd820;
    localparam int          RECIP_10_S = 13;
    // x/25 = (x*83887)>>21, exact for x < 65536
    localparam logic [16:0] RECIP_25   = 17'd83887;
    localparam int          RECIP_25_S = 21;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

    typedef struct packed {
        logic            zero;
        logic [ValW-1:0] val;
    } lane_res_t;

    typedef struct packed {
        logic [NumLanes-1:0] mask;
        logic [LaneIdxW-1:0] chan;
    } item_ctrl_t;

    // ceil(16000 / kbps) + 2 us
    function automatic logic [7:0] frame_time(input logic [1:0] rate);
        logic [7:0] t;
        unique case (rate)
            RATE_150: t = 8'd109;
            RATE_300: t = 8'd56;
            RATE_600: t = 8'd29;
            RATE_RSV: t = 8'd29;
        endcase
        return t;
    endfunction

    // command, telemetry bit 0, nibble XOR checksum
    function automatic logic [15:0] make_packet(input logic [CmdW-1:0] cmd);
        logic [11:0] payload;
        logic [3:0]  csum;
        payload = {cmd, 1'b0};
        csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
        return {payload, csum};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/dcf_lane.sv @@
`default_nettype none

// Per-lane value mapping: clamp, scale by span, divide by reciprocal.
module dcf_lane (
    input  wire logic                        clk,
    input  wire logic [1:0]                  kind,
    input  wire logic [dcf_pkg::ValW-1:0]    value,
    input  wire logic [dcf_pkg::CmdW-1:0]    span,
    input  wire logic [dcf_pkg::CmdW-1:0]    floor_val,
    input  wire dcf_pkg::pipe_en_t           en,
    output dcf_pkg::lane_res_t               res
);

    // stage 1
    logic                     s1_zero_reg, s1_zero_next;
    logic                     s1_raw_reg,  s1_raw_next;
    logic                     s1_pct_reg,  s1_pct_next;
    logic [dcf_pkg::ValW-1:0] s1_m_reg,    s1_m_next;
    logic [dcf_pkg::ValW-1:0] us_c;
    logic [9:0]               us_d;
    logic [19:0]              us_q;
    logic [6:0]               pct;

    // stage 2
    logic                      s2_zero_reg, s2_raw_reg, s2_pct_reg;
    logic [dcf_pkg::ValW-1:0]  s2_m_reg;
    logic [dcf_pkg::ProdW-1:0] s2_prod_reg, s2_prod_next;

    // stage 3
    logic                     s3_zero_reg;
    logic [dcf_pkg::ValW-1:0] s3_val_reg, s3_val_next;
    logic [dcf_pkg::ValW-1:0] div_x;
    logic [32:0]              div_p;
    logic [dcf_pkg::CmdW-1:0] quot;
    logic [11:0]              sum;

    always_comb
    begin
        us_c = (value > dcf_pkg::US_MAX) ? dcf_pkg::US_MAX : value;
        us_d = 10'(us_c - dcf_pkg::US_MIN);
        us_q = {10'd0, us_d} * {10'd0, dcf_pkg::RECIP_10};
        pct  = us_q[19:dcf_pkg::RECIP_10_S];

        s1_zero_next = 1'b0;
        s1_raw_next  = 1'b0;
        s1_pct_next  = 1'b0;
        s1_m_next    = '0;
        unique case (kind)
            dcf_pkg::KIND_RAW:
            begin
                s1_raw_next = 1'b1;
                s1_m_next   = value;
            end
            dcf_pkg::KIND_PCT:
            begin
                s1_pct_next  = 1'b1;
                s1_zero_next = (value == '0) || value[15];
                s1_m_next    = (value > dcf_pkg::PCT_FULL) ? dcf_pkg::PCT_FULL : value;
            end
            dcf_pkg::KIND_US:
            begin
                s1_zero_next = (value <= dcf_pkg::US_MIN) || (pct == '0);
                s1_m_next    = {9'd0, pct};
            end
            dcf_pkg::KIND_STOP:
            begin
                s1_zero_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_zero_reg <= s1_zero_next;
            s1_raw_reg  <= s1_raw_next;
            s1_pct_reg  <= s1_pct_next;
            s1_m_reg    <= s1_m_next;
        end
    end

    // operand is at most 25600, fits 15 bits
    assign s2_prod_next = {11'd0, s1_m_reg[14:0]} * {15'd0, span};

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_zero_reg <= s1_zero_reg;
            s2_raw_reg  <= s1_raw_reg;
            s2_pct_reg  <= s1_pct_reg;
            s2_m_reg    <= s1_m_reg;
            s2_prod_reg <= s2_prod_next;
        end
    end

    // /25600 = >>10 then /25; /100 = >>2 then /25
    always_comb
    begin
        div_x       = s2_pct_reg ? s2_prod_reg[25:10] : s2_prod_reg[17:2];
        div_p       = {17'd0, div_x} * {16'd0, dcf_pkg::RECIP_25};
        quot        = div_p[31:dcf_pkg::RECIP_25_S];
        sum         = {1'b0, floor_val} + {1'b0, quot};
        s3_val_next = s2_raw_reg ? s2_m_reg : {4'd0, sum};
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            s3_zero_reg <= s2_zero_reg;
            s3_val_reg  <= s3_val_next;
        end
    end

    assign res.zero = s3_zero_reg;
    assign res.val  = s3_val_reg;

endmodule

`default_nettype wire

@@ rtl/core/dcf_merge.sv @@
`default_nettype none

// Sanitize lane results, build packets, keep last commands, output register.
module dcf_merge (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dcf_pkg::lane_res_t            res [dcf_pkg::NumLanes],
    input  wire dcf_pkg::item_ctrl_t           ctrl,
    input  wire logic                          load,
    input  wire logic                          commit,
    input  wire logic [dcf_pkg::CmdW-1:0]      floor_val,
    input  wire logic [dcf_pkg::CmdW-1:0]      ceil_val,
    output logic                               accepted,
    output logic [dcf_pkg::NumLanes-1:0]       lane_mask,
    output logic [15:0]                        packet [dcf_pkg::NumLanes],
    output logic [dcf_pkg::CmdW-1:0]           selected_last_command
);

    logic [dcf_pkg::CmdW-1:0] cmd       [dcf_pkg::NumLanes];
    logic [dcf_pkg::CmdW-1:0] last_reg  [dcf_pkg::NumLanes];
    logic [dcf_pkg::CmdW-1:0] last_next [dcf_pkg::NumLanes];
    logic [15:0]              pkt_next  [dcf_pkg::NumLanes];
    logic [15:0]              pkt_reg   [dcf_pkg::NumLanes];
    logic                     accepted_reg;
    logic [dcf_pkg::NumLanes-1:0] mask_reg;
    logic [dcf_pkg::CmdW-1:0] sel_reg, sel_next;

    always_comb
    begin
        for (int i = 0; i < dcf_pkg::NumLanes; i++)
        begin
            if (res[i].zero || (res[i].val < {5'd0, floor_val}))
                cmd[i] = '0;
            else if (res[i].val > {5'd0, ceil_val})
                cmd[i] = ceil_val;
            else
                cmd[i] = res[i].val[dcf_pkg::CmdW-1:0];
            pkt_next[i]  = ctrl.mask[i] ? dcf_pkg::make_packet(cmd[i]) : 16'd0;
            last_next[i] = ctrl.mask[i] ? cmd[i] : last_reg[i];
        end
        // readout reflects this transaction's own update
        sel_next = last_next[ctrl.chan];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dcf_pkg::NumLanes; i++)
                last_reg[i] <= '0;
        end
        else if (commit)
        begin
            for (int i = 0; i < dcf_pkg::NumLanes; i++)
                last_reg[i] <= last_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            accepted_reg <= |ctrl.mask;
            mask_reg     <= ctrl.mask;
            sel_reg      <= sel_next;
            for (int i = 0; i < dcf_pkg::NumLanes; i++)
                pkt_reg[i] <= pkt_next[i];
        end
    end

    assign accepted              = accepted_reg;
    assign lane_mask             = mask_reg;
    assign packet                = pkt_reg;
    assign selected_last_command = sel_reg;

endmodule

`default_nettype wire

@@ rtl/core/dshot_command_framer_top.sv @@
// Each transaction runs through its lane's stage registers, then the merge output register.
// Throughput: one transaction per cycle unless the master stalls; four lane pipelines (clamp,
// span multiply, reciprocal divide) run side by side and a merge stage forms the result.
// Guard and next frame time resolve in the accept cycle; input stalls only when all four stages
// hold transactions and the master side is not ready. Reset (rst_n, async, active low):
// pipeline empty, registers at defaults, guard time and per-channel last commands cleared.
`default_nettype none

module dshot_command_framer_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // APB configuration
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request stream
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [1:0] channel, [5:2] lane_count, [21:6] value_0, [37:22] value_1,
    // [53:38] value_2, [69:54] value_3, [101:70] now_us, [103:102] zero
    input  wire logic [103:0]  s_axis_tdata,
    // [0] req_type, [2:1] value_kind
    input  wire logic [2:0]    s_axis_tuser,
    // result stream
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [3:0] lane_mask, [19:4] packet_0, [35:20] packet_1, [51:36] packet_2,
    // [67:52] packet_3, [78:68] selected_last_command, [79] zero
    output logic [79:0]        m_axis_tdata,
    // [0] accepted
    output logic [0:0]         m_axis_tuser
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [1:0]                rate_reg;
    logic [dcf_pkg::CmdW-1:0]  floor_reg;
    logic [dcf_pkg::CmdW-1:0]  ceil_reg;
    logic                      cfg_wr;
    logic [1:0]                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= dcf_pkg::RATE_RESET;
            floor_reg <= dcf_pkg::FLOOR_RESET;
            ceil_reg  <= dcf_pkg::CEIL_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                dcf_pkg::REG_RATE:  rate_reg  <= pwdata[1:0];
                dcf_pkg::REG_FLOOR: floor_reg <= pwdata[dcf_pkg::CmdW-1:0];
                dcf_pkg::REG_CEIL:  ceil_reg  <= pwdata[dcf_pkg::CmdW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            dcf_pkg::REG_RATE:  prdata = {30'd0, rate_reg};
            dcf_pkg::REG_FLOOR: prdata = {21'd0, floor_reg};
            dcf_pkg::REG_CEIL:  prdata = {21'd0, ceil_reg};
            default:            prdata = '0;
        endcase
    end

    // Inverted limits give an empty span.
    logic [dcf_pkg::CmdW-1:0] span;
    assign span = (ceil_reg >= floor_reg) ? (ceil_reg - floor_reg) : '0;

    // ---------------------------------------------------------------
    // Request fields
    // ---------------------------------------------------------------
    logic                      req_type;
    logic [1:0]                value_kind;
    logic [1:0]                channel;
    logic [3:0]                lane_count;
    logic [15:0]               value_in [dcf_pkg::NumLanes];
    logic [31:0]               now_us;

    assign req_type    = s_axis_tuser[0];
    assign value_kind  = s_axis_tuser[2:1];
    assign channel     = s_axis_tdata[1:0];
    assign lane_count  = s_axis_tdata[5:2];
    assign value_in[0] = s_axis_tdata[21:6];
    assign value_in[1] = s_axis_tdata[37:22];
    assign value_in[2] = s_axis_tdata[53:38];
    assign value_in[3] = s_axis_tdata[69:54];
    assign now_us      = s_axis_tdata[101:70];

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage moves when the next one is empty or moving.
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_xact;
    dcf_pkg::pipe_en_t en;

    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;
    assign in_xact       = s_axis_tvalid && rdy1;
    assign en.s1         = rdy1;
    assign en.s2         = rdy2;
    assign en.s3         = rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_xact;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------------------------------------------------------
    // Frame guard: decided at accept time against the stored frame time.
    // ---------------------------------------------------------------
    logic [31:0]                  nft_reg, nft_next;
    logic [31:0]                  guard_diff;
    logic                         busy;
    logic [dcf_pkg::NumLanes-1:0] want_mask;
    logic [dcf_pkg::NumLanes-1:0] grant_mask;

    assign guard_diff = now_us - nft_reg;
    assign busy       = guard_diff[31];

    always_comb
    begin
        for (int i = 0; i < dcf_pkg::NumLanes; i++)
        begin
            if (req_type)
                want_mask[i] = ({28'd0, lane_count} > i);
            else
                want_mask[i] = (channel == dcf_pkg::LaneIdxW'(i));
        end
        grant_mask = busy ? '0 : want_mask;
        nft_next   = now_us + {24'd0, dcf_pkg::frame_time(rate_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nft_reg <= '0;
        else if (in_xact && (grant_mask != '0))
            nft_reg <= nft_next;
    end

    // Item control travels alongside the lane pipelines.
    dcf_pkg::item_ctrl_t ctrl1_reg, ctrl2_reg, ctrl3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ctrl1_reg.mask <= grant_mask;
            ctrl1_reg.chan <= channel;
        end
        if (rdy2) ctrl2_reg <= ctrl1_reg;
        if (rdy3) ctrl3_reg <= ctrl2_reg;
    end

    // ---------------------------------------------------------------
    // Lanes: single send maps value_0 in the target channel's lane.
    // ---------------------------------------------------------------
    dcf_pkg::lane_res_t lane_res [dcf_pkg::NumLanes];

    for (genvar g = 0; g < dcf_pkg::NumLanes; g++)
    begin : g_lane
        dcf_lane u_lane (
            .clk       (clk),
            .kind      (value_kind),
            .value     (req_type ? value_in[g] : value_in[0]),
            .span      (span),
            .floor_val (floor_reg),
            .en        (en),
            .res       (lane_res[g])
        );
    end

    // ---------------------------------------------------------------
    // Merge and output register
    // ---------------------------------------------------------------
    logic                         accepted;
    logic [dcf_pkg::NumLanes-1:0] lane_mask;
    logic [15:0]                  packet [dcf_pkg::NumLanes];
    logic [dcf_pkg::CmdW-1:0]     selected_last_command;

    dcf_merge u_merge (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .res                   (lane_res),
        .ctrl                  (ctrl3_reg),
        .load                  (rdy4),
        .commit                (rdy4 && v3_reg),
        .floor_val             (floor_reg),
        .ceil_val              (ceil_reg),
        .accepted              (accepted),
        .lane_mask             (lane_mask),
        .packet                (packet),
        .selected_last_command (selected_last_command)
    );

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tuser  = accepted;
    assign m_axis_tdata  = {1'b0, selected_last_command, packet[3], packet[2],
                            packet[1], packet[0], lane_mask};

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    // request type codes on tuser[0]
    localparam logic REQ_SINGLE = 1'b0;
    localparam logic REQ_GROUP  = 1'b1;

    // long receiver hold-off, in clock cycles
    localparam int HOLD_OFF_CYCLES = 300;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic             req_type;
        logic [1:0]       kind;
        logic [1:0]       chan;
        logic [3:0]       lanes;
        logic [3:0][15:0] val;
        logic [31:0]      now;
    } request_t;

    typedef struct packed {
        logic             accepted;
        logic [3:0]       mask;
        logic [3:0][15:0] pkt;
        logic [10:0]      last;
    } frame_result_t;

    typedef struct packed {
        request_t      rq;
        logic          typed;
        frame_result_t want;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    // predictor state and register copy
    logic [1:0]  cfg_rate = dcf_pkg::RATE_RESET;
    logic [10:0] cfg_floor = dcf_pkg::FLOOR_RESET;
    logic [10:0] cfg_ceil = dcf_pkg::CEIL_RESET;
    logic [31:0] next_slot_us = '0;
    logic [10:0] last_cmd [4] = '{default: '0};

    frame_result_t frame_queue [$];
    int            mismatches = 0;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    int            hold_asks = 0;

    dshot_command_framer_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [10:0] clamp_command(input int unsigned v);
        if (v < cfg_floor)
            return '0;
        if (v > cfg_ceil)
            return cfg_ceil;
        return 11'(v);
    endfunction

    function automatic logic [10:0] map_command(input logic [1:0] kind, input logic [15:0] v);
        int unsigned x;
        int unsigned span;
        int unsigned pct;
        span = (cfg_ceil >= cfg_floor) ? cfg_ceil - cfg_floor : 0;
        x = v;
        case (kind)
            dcf_pkg::KIND_RAW:
                return clamp_command(x);
            dcf_pkg::KIND_PCT:
            begin
                // Q7.8, negative or zero means off
                if (x == 0 || v[15])
                    return '0;
                if (x > dcf_pkg::PCT_FULL)
                    x = dcf_pkg::PCT_FULL;
                return clamp_command(cfg_floor + x * span / dcf_pkg::PCT_FULL);
            end
            dcf_pkg::KIND_US:
            begin
                if (x <= dcf_pkg::US_MIN)
                    return '0;
                if (x > dcf_pkg::US_MAX)
                    x = dcf_pkg::US_MAX;
                pct = (x - dcf_pkg::US_MIN) * 100 / (dcf_pkg::US_MAX - dcf_pkg::US_MIN);
                if (pct == 0)
                    return '0;
                return clamp_command(cfg_floor + pct * span / 100);
            end
            default:
                return '0;
        endcase
    endfunction

    // 11-bit command, telemetry 0, XOR of the three upper nibbles
    function automatic logic [15:0] dshot_word(input logic [10:0] cmd);
        logic [15:0] w;
        w = {cmd, 5'b0};
        w[3:0] = w[15:12] ^ w[11:8] ^ w[7:4];
        return w;
    endfunction

    function automatic int unsigned frame_period_us();
        int unsigned kbps;
        case (cfg_rate)
            dcf_pkg::RATE_150: kbps = 150;
            dcf_pkg::RATE_300: kbps = 300;
            default:           kbps = 600;   // reserved code runs at 600 too
        endcase
        return (16000 + kbps - 1) / kbps + 2;
    endfunction

    function automatic frame_result_t predict_frame(input request_t rq);
        frame_result_t res;
        logic [31:0]   gap;
        logic [10:0]   cmd;
        int unsigned   n;
        res = '0;
        gap = rq.now - next_slot_us;
        if (!gap[31])
        begin
            if (rq.req_type == REQ_SINGLE)
            begin
                cmd = map_command(rq.kind, rq.val[0]);
                res.pkt[rq.chan] = dshot_word(cmd);
                res.mask[rq.chan] = 1'b1;
                last_cmd[rq.chan] = cmd;
            end
            else
            begin
                n = (rq.lanes > dcf_pkg::NumLanes) ? dcf_pkg::NumLanes : rq.lanes;
                for (int i = 0; i < n; i++)
                begin
                    cmd = map_command(rq.kind, rq.val[i]);
                    res.pkt[i] = dshot_word(cmd);
                    res.mask[i] = 1'b1;
                    last_cmd[i] = cmd;
                end
            end
            if (res.mask != '0)
                next_slot_us = rq.now + frame_period_us();
        end
        res.accepted = (res.mask != '0);
        res.last = last_cmd[rq.chan];
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        frame_result_t got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.accepted = m_axis_tuser[0];
            got.mask     = m_axis_tdata[3:0];
            got.pkt      = m_axis_tdata[67:4];
            got.last     = m_axis_tdata[78:68];
            if (frame_queue.size() == 0)
            begin
                $error("result transaction with nothing expected: 0x%0h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = frame_queue.pop_front();
                compare_field("accepted", want.accepted, got.accepted);
                compare_field("lane_mask", want.mask, got.mask);
                for (int i = 0; i < 4; i++)
                    compare_field($sformatf("packet_%0d", i), want.pkt[i], got.pkt[i]);
                compare_field("selected_last_command", want.last, got.last);
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // random stalls, plus a long hold-off on request so the pipe backs up
    always @(posedge clk)
    begin : sink_side
        int hold_left;
        int hold_seen;
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(1, 100) > sink_stall_pct);
    end

    // ---------------------------------------------------------------- sender

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SRC:  begin src_idle_pct = 59; sink_stall_pct = 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 59; end
            IDLE_BOTH: begin src_idle_pct = 23; sink_stall_pct = 23; end
            default:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        endcase
    endtask

    // tvalid stays high after acceptance unless the next call idles
    task automatic send_item(input stim_row_t r);
        frame_result_t predicted;
        while (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.rq.now, r.rq.val, r.rq.lanes, r.rq.chan};
        s_axis_tuser  <= {r.rq.kind, r.rq.req_type};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_frame(r.rq);
        frame_queue.push_back(r.typed ? r.want : predicted);
    endtask

    function automatic stim_row_t req_row(input logic req, input logic [1:0] kind,
                                          input logic [1:0] chan, input logic [3:0] lanes,
                                          input logic [15:0] v0, input logic [15:0] v1,
                                          input logic [15:0] v2, input logic [15:0] v3,
                                          input logic [31:0] now);
        stim_row_t r;
        r = '0;
        r.rq.req_type = req;
        r.rq.kind     = kind;
        r.rq.chan     = chan;
        r.rq.lanes    = lanes;
        r.rq.val      = {v3, v2, v1, v0};
        r.rq.now      = now;
        return r;
    endfunction

    function automatic stim_row_t pin_result(input stim_row_t r, input logic acc,
                                             input logic [3:0] mask, input logic [15:0] p0,
                                             input logic [15:0] p1, input logic [15:0] p2,
                                             input logic [15:0] p3, input logic [10:0] last);
        r.typed         = 1'b1;
        r.want.accepted = acc;
        r.want.mask     = mask;
        r.want.pkt      = {p3, p2, p1, p0};
        r.want.last     = last;
        return r;
    endfunction

    function automatic logic [15:0] random_value(input logic [1:0] kind);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return 16'($urandom);
        case (kind)
            dcf_pkg::KIND_RAW: return 16'($urandom_range(0, 2100));
            dcf_pkg::KIND_PCT: return 16'($urandom_range(0, 26000));
            dcf_pkg::KIND_US:  return 16'($urandom_range(950, 2050));
            default:           return 16'($urandom);
        endcase
    endfunction

    // mostly well-timed requests just past the guard, some early, some far off
    function automatic stim_row_t random_row();
        stim_row_t   r;
        int unsigned roll;
        r = '0;
        r.rq.req_type = 1'($urandom_range(0, 1));
        r.rq.kind     = 2'($urandom_range(0, 3));
        r.rq.chan     = 2'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        r.rq.lanes = (roll < 25) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
        for (int i = 0; i < 4; i++)
            r.rq.val[i] = random_value(r.rq.kind);
        roll = $urandom_range(0, 99);
        if (roll < 65)
            r.rq.now = next_slot_us + $urandom_range(0, 40);
        else if (roll < 80)
            r.rq.now = next_slot_us - $urandom_range(1, 120);
        else if (roll < 85)
            r.rq.now = next_slot_us;
        else if (roll < 88)
            r.rq.now = next_slot_us - 1;
        else if (roll < 92)
            r.rq.now = next_slot_us + 32'h7FFF_FFFF - $urandom_range(0, 3);
        else if (roll < 94)
            r.rq.now = next_slot_us + 32'h8000_0000;
        else
            r.rq.now = $urandom;
        return r;
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send_item(random_row());
    endtask

    // ---------------------------------------------------------------- APB

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] stored;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            dcf_pkg::REG_RATE:
            begin
                cfg_rate = value[1:0];
                stored = {30'b0, cfg_rate};
            end
            dcf_pkg::REG_FLOOR:
            begin
                cfg_floor = value[10:0];
                stored = {21'b0, cfg_floor};
            end
            default:
            begin
                cfg_ceil = value[10:0];
                stored = {21'b0, cfg_ceil};
            end
        endcase
        apb_access(1'b0, idx, 32'b0, rd);
        compare_field($sformatf("register %0d readback", idx), stored, rd);
    endtask

    // stop offering, let every expected transaction come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (frame_queue.size() != 0)
            @(posedge clk);
    endtask

    // new register setting with junk in the unused upper bits, then random traffic
    task automatic run_phase(input logic [1:0] rate, input logic [10:0] floor_v,
                             input logic [10:0] ceil_v, input idle_mode_t mode, input int n);
        logic [31:0] junk;
        drain();
        junk = $urandom;
        set_register(dcf_pkg::REG_RATE, {junk[31:2], rate});
        junk = $urandom;
        set_register(dcf_pkg::REG_FLOOR, {junk[31:11], floor_v});
        junk = $urandom;
        set_register(dcf_pkg::REG_CEIL, {junk[31:11], ceil_v});
        set_idle(mode);
        run_random(n);
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin : main
        stim_row_t dir_rows [18];

        // reset settings: floor 48, ceiling 2047, 56 us frame
        dir_rows[0]  = pin_result(req_row(REQ_SINGLE, dcf_pkg::KIND_RAW, 2'd0, 4'd0,
                                          16'd2047, 16'd0, 16'd0, 16'd0, 32'd0),
                                  1'b1, 4'b0001, 16'hFFEE, 16'h0, 16'h0, 16'h0, 11'd2047);
        // inside the guard time
        dir_rows[1]  = pin_result(req_row(REQ_SINGLE, dcf_pkg::KIND_RAW, 2'd0, 4'd0,
                                          16'd5, 16'd0, 16'd0, 16'd0, 32'd55),
                                  1'b0, 4'b0000, 16'h0, 16'h0, 16'h0, 16'h0, 11'd2047);
        // one below floor sends zero
        dir_rows[2]  = pin_result(req_row(REQ_SINGLE, dcf_pkg::KIND_RAW, 2'd1, 4'd0,
                                          16'd47, 16'd0, 16'd0, 16'd0, 32'd56),
                                  1'b1, 4'b0010, 16'h0, 16'h0, 16'h0, 16'h0, 11'd0);
        // empty group is dropped
        dir_rows[3]  = pin_result(req_row(REQ_GROUP, dcf_pkg::KIND_RAW, 2'd0, 4'd0,
                                          16'd100, 16'd100, 16'd100, 16'd100, 32'd112),
                                  1'b0, 4'b0000, 16'h0, 16'h0, 16'h0, 16'h0, 11'd2047);
        // oversized group saturates to four lanes
        dir_rows[4]  = req_row(REQ_GROUP, dcf_pkg::KIND_RAW, 2'd2, 4'd15,
                               16'd0, 16'd48, 16'hFFFF, 16'd1000, 32'd112);
        // far in the past wraps to negative: dropped
        dir_rows[5]  = pin_result(req_row(REQ_SINGLE, dcf_pkg::KIND_RAW, 2'd3, 4'd0,
                                          16'hFFFF, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF),
                                  1'b0, 4'b0000, 16'h0, 16'h0, 16'h0, 16'h0, 11'd1000);
        // percent: negative, zero, full scale, over full scale
        dir_rows[6]  = req_row(REQ_GROUP, dcf_pkg::KIND_PCT, 2'd0, 4'd4,
                               16'h8000, 16'd0, 16'd25600, 16'h7FFF, 32'd168);
        dir_rows[7]  = req_row(REQ_GROUP, dcf_pkg::KIND_PCT, 2'd1, 4'd2,
                               16'd1, 16'd12800, 16'd0, 16'd0, 32'd224);
        // microseconds: at minimum, truncates to zero percent, first step, max
        dir_rows[8]  = req_row(REQ_GROUP, dcf_pkg::KIND_US, 2'd3, 4'd4,
                               16'd1000, 16'd1009, 16'd1010, 16'd2000, 32'd280);
        dir_rows[9]  = req_row(REQ_GROUP, dcf_pkg::KIND_US, 2'd2, 4'd3,
                               16'd1500, 16'hFFFF, 16'd999, 16'd0, 32'd336);
        // stop ignores the value
        dir_rows[10] = pin_result(req_row(REQ_SINGLE, dcf_pkg::KIND_STOP, 2'd2, 4'd0,
                                          16'hFFFF, 16'd0, 16'd0, 16'd0, 32'd392),
                                  1'b1, 4'b0100, 16'h0, 16'h0, 16'h0, 16'h0, 11'd0);
        dir_rows[11] = pin_result(req_row(REQ_GROUP, dcf_pkg::KIND_STOP, 2'd3, 4'd4,
                                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd448),
                                  1'b1, 4'b1111, 16'h0, 16'h0, 16'h0, 16'h0, 11'd0);
        dir_rows[12] = req_row(REQ_SINGLE, dcf_pkg::KIND_RAW, 2'd3, 4'd0,
                               16'd48, 16'd0, 16'd0, 16'd0, 32'd504);
        dir_rows[13] = req_row(REQ_SINGLE, dcf_pkg::KIND_PCT, 2'd0, 4'd0,
                               16'd1, 16'd0, 16'd0, 16'd0, 32'd560);
        // largest positive distance still passes the guard
        dir_rows[14] = req_row(REQ_GROUP, dcf_pkg::KIND_RAW, 2'd1, 4'd5,
                               16'd2046, 16'd2048, 16'd49, 16'd47, 32'h8000_0267);
        // timestamp wrapped around zero
        dir_rows[15] = req_row(REQ_SINGLE, dcf_pkg::KIND_RAW, 2'd0, 4'd0,
                               16'h0400, 16'd0, 16'd0, 16'd0, 32'd0);
        dir_rows[16] = pin_result(req_row(REQ_SINGLE, dcf_pkg::KIND_RAW, 2'd1, 4'd0,
                                          16'd1234, 16'd0, 16'd0, 16'd0, 32'd55),
                                  1'b0, 4'b0000, 16'h0, 16'h0, 16'h0, 16'h0, 11'd2047);
        dir_rows[17] = req_row(REQ_SINGLE, dcf_pkg::KIND_RAW, 2'd1, 4'd0,
                               16'd1234, 16'd0, 16'd0, 16'd0, 32'd56);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(IDLE_NONE);
        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        // receiver holds off while the sender keeps offering
        hold_asks++;
        run_random(180);

        run_phase(dcf_pkg::RATE_150, 11'd0,    11'd2047, IDLE_SRC,  190);
        run_phase(dcf_pkg::RATE_600, 11'd2047, 11'd2047, IDLE_SINK, 190);
        // ceiling below floor
        run_phase(dcf_pkg::RATE_RSV, 11'd100,  11'd0,    IDLE_BOTH, 190);
        run_phase(dcf_pkg::RATE_300, 11'd0,    11'd0,    IDLE_NONE, 190);
        run_phase(dcf_pkg::RATE_150, 11'd1000, 11'd1500, IDLE_SRC,  190);
        run_phase(2'($urandom_range(0, 3)), 11'($urandom_range(0, 300)),
                  11'($urandom_range(1000, 2047)), IDLE_SINK, 190);
        run_phase(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)),
                  11'($urandom_range(0, 2047)), IDLE_BOTH, 190);
        run_phase(2'($urandom_range(0, 3)), 11'($urandom_range(0, 300)),
                  11'($urandom_range(1000, 2047)), IDLE_NONE, 190);

        drain();
        repeat (10) @(posedge clk);
        if (frame_queue.size() != 0)
            $error("%0d expected transactions never arrived", frame_queue.size());

        if (mismatches == 0 && frame_queue.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dcf_pkg.sv
rtl/core/dcf_lane.sv
rtl/core/dcf_merge.sv
rtl/core/dshot_command_framer_top.sv
tb/sv/testbench.sv
